[hw/rtl/strongly_connected_components_top_macros.svh]
// assertion macros for the scc block
`ifndef STRONGLY_CONNECTED_COMPONENTS_TOP_MACROS_SVH
`define STRONGLY_CONNECTED_COMPONENTS_TOP_MACROS_SVH

// checked outside reset
`define SCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define SCC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/scc_pkg.sv]
`default_nettype none
package scc_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int MAX_EDGES    = 256;
  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int CW  = $clog2(MAX_VERTICES + 1);
  localparam int EAW = $clog2(MAX_EDGES);
  localparam int ETW = $clog2(MAX_EDGES + 1);

  typedef struct packed {
    logic accept;
    logic clear_run;
    logic start_walk;
    logic walk_from_finish;
    logic rd_edge;
    logic found_step;
    logic skip_step;
    logic pop;
    logic pop_load;
    logic p1_skip;
    logic p1_to_p2;
    logic p2_read;
    logic flush;
  } scc_cmd_t;

  typedef struct packed {
    logic last_item;
    logic scan_more;
    logic found;
    logic out_free;
    logic i_done;
    logic i_visited;
    logic stack_last;
    logic fd_zero;
    logic cand_ok;
    logic rev;
  } scc_status_t;

endpackage
`default_nettype wire

[hw/rtl/strongly_connected_components_top.sv]
// strongly connected components of a directed graph
// s_axis carries one directed edge per item; s_axis_tlast marks the last
// item of a graph and starts the run. s_axis_tuser says the item holds an edge.
// edges load one per cycle while s_axis_tready is high; it drops for the run.
// the run is two depth-first passes over the edge memory: each scan step
// is a memory read, then a compare.
// m_axis gives one item per vertex (vertex_count clipped to 1..64, in all) in second-pass
// order, with component number; tuser holds component end and dropped flag,
// tlast marks the final item of the run.
// bad or overflowing edges are dropped and reported on every result.
// a stalled receiver holds the output register; the walk waits on it.
// cfg_wr_en/cfg_wr_data write vertex_count (reset 64); the user writes it only while idle (not enforced).
// synchronous reset empties the graph and clears the output.
`default_nettype none
module strongly_connected_components_top (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_wr_en,
  input  wire  [6:0]  cfg_wr_data,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [15:0] s_axis_tdata,   // edge_from[6:0], edge_to[13:7]
  input  wire         s_axis_tuser,   // edge_present
  input  wire         s_axis_tlast,   // last_edge
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [15:0] m_axis_tdata,   // vertex[6:0], component_number[12:7]
  output logic [1:0]  m_axis_tuser,   // component_end[0], edges_dropped[1]
  output logic        m_axis_tlast    // last_result
);
  import scc_pkg::*;

  scc_cmd_t    cmd;
  scc_status_t sts;

  scc_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts           (sts),
    .cmd           (cmd)
  );

  scc_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule
`default_nettype wire

[hw/rtl/scc_ctrl.sv]
`default_nettype none
module scc_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 s_axis_tvalid,
  output logic                s_axis_tready,
  input  scc_pkg::scc_status_t sts,
  output scc_pkg::scc_cmd_t    cmd
);
  import scc_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_P1_NEXT  = 4'd1;
  localparam logic [3:0] S_SCAN_RD  = 4'd2;
  localparam logic [3:0] S_SCAN_CHK = 4'd3;
  localparam logic [3:0] S_POP      = 4'd4;
  localparam logic [3:0] S_POP_LD   = 4'd5;
  localparam logic [3:0] S_FLUSH    = 4'd6;
  localparam logic [3:0] S_P2_NEXT  = 4'd7;
  localparam logic [3:0] S_P2_CHK   = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_axis_tready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.accept = s_axis_tvalid;
        if (s_axis_tvalid && sts.last_item) state_next = S_P1_NEXT;
      end
      S_P1_NEXT: begin
        if (sts.i_done) begin
          cmd.p1_to_p2 = 1'b1;
          state_next = S_P2_NEXT;
        end else if (sts.i_visited) begin
          cmd.p1_skip = 1'b1;
        end else begin
          cmd.start_walk = 1'b1;
          state_next = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (sts.scan_more) begin
          cmd.rd_edge = 1'b1;
          state_next = S_SCAN_CHK;
        end else begin
          state_next = S_POP;
        end
      end
      S_SCAN_CHK: begin
        if (sts.found) begin
          if (!(sts.rev && !sts.out_free)) begin
            cmd.found_step = 1'b1;
            state_next = S_SCAN_RD;
          end
        end else begin
          cmd.skip_step = 1'b1;
          state_next = S_SCAN_RD;
        end
      end
      S_POP: begin
        cmd.pop = 1'b1;
        if (sts.stack_last) state_next = sts.rev ? S_FLUSH : S_P1_NEXT;
        else state_next = S_POP_LD;
      end
      S_POP_LD: begin
        cmd.pop_load = 1'b1;
        state_next = S_SCAN_RD;
      end
      S_FLUSH: begin
        if (sts.out_free) begin
          cmd.flush = 1'b1;
          state_next = S_P2_NEXT;
        end
      end
      S_P2_NEXT: begin
        if (sts.fd_zero) begin
          state_next = S_DONE;
        end else begin
          cmd.p2_read = 1'b1;
          state_next = S_P2_CHK;
        end
      end
      S_P2_CHK: begin
        if (sts.cand_ok) begin
          cmd.start_walk = 1'b1;
          cmd.walk_from_finish = 1'b1;
          state_next = S_SCAN_RD;
        end else begin
          state_next = S_P2_NEXT;
        end
      end
      S_DONE: begin
        cmd.clear_run = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[hw/rtl/scc_datapath.sv]
`default_nettype none
module scc_datapath (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  cfg_wr_en,
  input  wire  [6:0]           cfg_wr_data,
  input  wire  [15:0]          s_axis_tdata,
  input  wire                  s_axis_tuser,
  input  wire                  s_axis_tlast,
  output logic                 m_axis_tvalid,
  input  wire                  m_axis_tready,
  output logic [15:0]          m_axis_tdata,
  output logic [1:0]           m_axis_tuser,
  output logic                 m_axis_tlast,
  input  scc_pkg::scc_cmd_t    cmd,
  output scc_pkg::scc_status_t sts
);
  import scc_pkg::*;

  logic [CW-1:0]     vertex_count, n;
  logic [6:0]        in_from, in_to;
  logic              edge_ok;
  logic [2*VW-1:0]   edge_mem [MAX_EDGES];
  logic [2*VW-1:0]   edge_rd;
  logic [VW+ETW-1:0] stk_mem [MAX_VERTICES];
  logic [VW+ETW-1:0] stk_rd;
  logic [VW-1:0]     fin_mem [MAX_VERTICES];
  logic [VW-1:0]     fin_rd;
  logic [MAX_VERTICES-1:0] visited;
  logic [ETW-1:0]    edge_total, cur_p, cur_p_inc;
  logic              drop, rev;
  logic [CW-1:0]     i_cnt, sp, sp_dec, sp_dec2, fd, fd_dec, emit_cnt;
  logic [VW-1:0]     cur_v, pend_v, start_v;
  logic [VW-1:0]     comp;
  logic [VW-1:0]     e_src, e_dst, key, nbr;
  logic              found, bad_edge, push_ok;
  logic [6:0]        out_vertex;
  logic [VW-1:0]     out_comp;
  logic              out_end, out_last, out_drop;

  always_comb begin
    if (vertex_count == '0) n = CW'(1);
    else if (vertex_count > CW'(MAX_VERTICES)) n = CW'(MAX_VERTICES);
    else n = vertex_count;
  end

  assign in_from = s_axis_tdata[6:0];
  assign in_to   = s_axis_tdata[13:7];
  assign edge_ok = (in_from != 7'd0) && ({1'b0, in_from} <= {1'b0, n}) &&
                   (in_to != 7'd0) && ({1'b0, in_to} <= {1'b0, n}) &&
                   (edge_total < ETW'(MAX_EDGES));

  assign e_src    = edge_rd[2*VW-1:VW];
  assign e_dst    = edge_rd[VW-1:0];
  assign key      = rev ? e_dst : e_src;
  assign nbr      = rev ? e_src : e_dst;
  assign found    = (key == cur_v) && ({1'b0, nbr} < n) && !visited[nbr];
  assign bad_edge = ({1'b0, e_src} >= n) || ({1'b0, e_dst} >= n);
  assign push_ok  = (sp < CW'(MAX_VERTICES));
  assign cur_p_inc = cur_p + ETW'(1);
  assign sp_dec   = sp - CW'(1);
  assign sp_dec2  = sp - CW'(2);
  assign fd_dec   = fd - CW'(1);
  assign start_v  = cmd.walk_from_finish ? fin_rd : i_cnt[VW-1:0];

  // memories
  always_ff @(posedge clk) begin
    if (cmd.accept && s_axis_tuser && edge_ok) begin
      edge_mem[edge_total[EAW-1:0]] <= {VW'(in_from - 7'd1), VW'(in_to - 7'd1)};
    end
    if (cmd.rd_edge) edge_rd <= edge_mem[cur_p[EAW-1:0]];
    if (cmd.found_step && push_ok) stk_mem[sp_dec[VW-1:0]] <= {cur_v, cur_p_inc};
    if (cmd.pop) stk_rd <= stk_mem[sp_dec2[VW-1:0]];
    if (cmd.pop && !rev && (fd < CW'(MAX_VERTICES))) fin_mem[fd[VW-1:0]] <= cur_v;
    if (cmd.p2_read) fin_rd <= fin_mem[fd_dec[VW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count  <= CW'(MAX_VERTICES);
      edge_total    <= '0;
      drop          <= 1'b0;
      rev           <= 1'b0;
      visited       <= '0;
      i_cnt         <= '0;
      sp            <= '0;
      fd            <= '0;
      comp          <= '0;
      emit_cnt      <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_wr_en) vertex_count <= cfg_wr_data;
      if (cmd.flush || (cmd.found_step && rev)) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
      if (cmd.accept && s_axis_tuser) begin
        if (edge_ok) edge_total <= edge_total + ETW'(1);
        else drop <= 1'b1;
      end
      if (cmd.start_walk) begin
        visited[start_v] <= 1'b1;
        cur_v <= start_v;
        cur_p <= '0;
        sp    <= CW'(1);
        if (rev) pend_v <= start_v;
        if (!cmd.walk_from_finish) i_cnt <= i_cnt + CW'(1);
      end
      if (cmd.p1_skip) i_cnt <= i_cnt + CW'(1);
      if (cmd.found_step) begin
        visited[nbr] <= 1'b1;
        if (rev) begin
          out_vertex    <= {1'b0, pend_v} + 7'd1;
          out_comp      <= comp;
          out_end       <= 1'b0;
          out_last      <= 1'b0;
          out_drop      <= drop;
          emit_cnt      <= emit_cnt + CW'(1);
          pend_v        <= nbr;
        end
        if (push_ok) begin
          cur_v <= nbr;
          cur_p <= '0;
          sp    <= sp + CW'(1);
        end else begin
          cur_p <= cur_p_inc;
        end
      end
      if (cmd.skip_step) begin
        cur_p <= cur_p_inc;
        if (bad_edge) drop <= 1'b1;
      end
      if (cmd.pop) begin
        sp <= sp_dec;
        if (!rev && (fd < CW'(MAX_VERTICES))) fd <= fd + CW'(1);
      end
      if (cmd.pop_load) {cur_v, cur_p} <= stk_rd;
      if (cmd.p1_to_p2) begin
        rev     <= 1'b1;
        visited <= '0;
      end
      if (cmd.p2_read) fd <= fd_dec;
      if (cmd.flush) begin
        out_vertex    <= {1'b0, pend_v} + 7'd1;
        out_comp      <= comp;
        out_end       <= 1'b1;
        out_last      <= (emit_cnt == n - CW'(1));
        out_drop      <= drop;
        emit_cnt      <= emit_cnt + CW'(1);
        comp          <= comp + VW'(1);
      end
      if (cmd.clear_run) begin
        edge_total <= '0;
        drop       <= 1'b0;
        rev        <= 1'b0;
        visited    <= '0;
        i_cnt      <= '0;
        fd         <= '0;
        comp       <= '0;
        emit_cnt   <= '0;
      end
    end
  end

  assign m_axis_tdata = {3'b000, out_comp, out_vertex};
  assign m_axis_tuser = {out_drop, out_end};
  assign m_axis_tlast = out_last;

  always_comb begin
    sts.last_item  = s_axis_tlast;
    sts.scan_more  = (cur_p < edge_total);
    sts.found      = found;
    sts.out_free   = !m_axis_tvalid || m_axis_tready;
    sts.i_done     = (i_cnt >= n);
    sts.i_visited  = visited[i_cnt[VW-1:0]];
    sts.stack_last = (sp == CW'(1));
    sts.fd_zero    = (fd == '0);
    sts.cand_ok    = ({1'b0, fin_rd} < n) && !visited[fin_rd];
    sts.rev        = rev;
  end

endmodule
`default_nettype wire

[hw/rtl/scc_checker.sv]
`default_nettype none
`include "strongly_connected_components_top_macros.svh"
module scc_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire        s_axis_tlast,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [1:0]  m_axis_tuser,
  input wire        m_axis_tlast
);

  `SCC_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "output dropped")
  `SCC_ASSERT(a_last_ends_comp, m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0], "last not end")
  `SCC_ASSERT(a_busy_after_last, s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready, "run not started")
  `SCC_ASSERT_ALWAYS(a_reset_quiet, rst |=> !m_axis_tvalid, "output after reset")

endmodule

bind strongly_connected_components_top scc_checker u_scc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

[verif/strongly_connected_components_top_tb.sv]
`timescale 1ns / 1ps
module strongly_connected_components_top_tb;
  import scc_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE_CYCLES = 300;

  typedef struct {
    logic [6:0] vertex;
    logic [5:0] comp;
    bit         comp_end;
    bit         run_end;
    bit         dropped;
  } vertex_result_t;

  typedef struct {
    bit             cfg_en;
    logic [6:0]     cfg_val;
    logic [6:0]     from_v;
    logic [6:0]     to_v;
    bit             present;
    bit             closing;
    bit             typed;
    vertex_result_t typed_res;
  } edge_row_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_wr_en = 0;
  logic [6:0]  cfg_wr_data = '0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 0;
  logic        s_axis_tlast = 0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  strongly_connected_components_top i_dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .s_axis_tlast(s_axis_tlast), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast)
  );

  always #5 clk = ~clk;

  // graph model state
  logic [6:0]     vcount_reg = 7'd64;
  logic [5:0]     edge_src [MAX_EDGES];
  logic [5:0]     edge_dst [MAX_EDGES];
  int             edge_cnt = 0;
  bit             drop_seen = 0;
  bit             seen [MAX_VERTICES];
  int             fin_order [MAX_VERTICES];
  int             fin_depth;
  int             stk_v [MAX_VERTICES];
  int             stk_p [MAX_VERTICES];
  vertex_result_t run_out [$];
  vertex_result_t pending_vertices [$];
  int             errors = 0;
  int             cycles = 0;
  bit             quiet = 0;
  int             stall_left = 0;

  function automatic int live_count();
    int n;
    n = vertex_count_clip(vcount_reg);
    return n;
  endfunction

  function automatic int vertex_count_clip(logic [6:0] v);
    if (v < 1) return 1;
    if (v > MAX_VERTICES) return MAX_VERTICES;
    return v;
  endfunction

  function automatic void emit_vertex(int w, int comp);
    vertex_result_t r;
    r.vertex = 7'(w + 1);
    r.comp = 6'(comp);
    r.comp_end = 0;
    r.run_end = 0;
    r.dropped = 0;
    run_out = {run_out, r};
  endfunction

  function automatic void depth_walk(int start, bit rev, int n, int comp);
    int sp, top, v, p, w, key;
    bit pushed;
    seen[start] = 1;
    if (rev) emit_vertex(start, comp);
    stk_v[0] = start;
    stk_p[0] = 0;
    sp = 1;
    while (sp > 0) begin
      top = sp - 1;
      v = stk_v[top];
      p = stk_p[top];
      pushed = 0;
      while (p < edge_cnt) begin
        key = rev ? edge_dst[p] : edge_src[p];
        w = rev ? edge_src[p] : edge_dst[p];
        p++;
        if (key == v && w < n && !seen[w]) begin
          stk_p[top] = p;
          seen[w] = 1;
          if (rev) emit_vertex(w, comp);
          if (sp < MAX_VERTICES) begin
            stk_v[sp] = w;
            stk_p[sp] = 0;
            sp++;
          end
          pushed = 1;
          break;
        end
      end
      if (!pushed) begin
        sp--;
        if (!rev && fin_depth < MAX_VERTICES) begin
          fin_order[fin_depth] = v;
          fin_depth++;
        end
      end
    end
  endfunction

  function automatic void find_components();
    int n, comp, v, prior;
    n = live_count();
    comp = 0;
    run_out.delete();
    for (int i = 0; i < edge_cnt; i++)
      if (edge_src[i] >= n || edge_dst[i] >= n) drop_seen = 1;
    foreach (seen[i]) seen[i] = 0;
    fin_depth = 0;
    for (int i = 0; i < n; i++)
      if (!seen[i]) depth_walk(i, 0, n, 0);
    foreach (seen[i]) seen[i] = 0;
    while (fin_depth > 0) begin
      fin_depth--;
      v = fin_order[fin_depth];
      if (v < n && !seen[v]) begin
        prior = run_out.size();
        depth_walk(v, 1, n, comp);
        if (run_out.size() > prior) run_out[run_out.size() - 1].comp_end = 1;
        comp++;
      end
    end
    if (run_out.size() > 0) begin
      foreach (run_out[k]) run_out[k].dropped = drop_seen;
      run_out[run_out.size() - 1].run_end = 1;
    end
    edge_cnt = 0;
    drop_seen = 0;
  endfunction

  // returns 1 when the item closed a graph and run_out holds its vertices
  function automatic bit take_edge(logic [6:0] f, logic [6:0] t, bit present, bit closing);
    int n;
    n = live_count();
    if (present) begin
      if (f < 1 || f > n || t < 1 || t > n || edge_cnt >= MAX_EDGES) drop_seen = 1;
      else begin
        edge_src[edge_cnt] = 6'(f - 1);
        edge_dst[edge_cnt] = 6'(t - 1);
        edge_cnt++;
      end
    end
    if (!closing) return 0;
    find_components();
    return 1;
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_edge(logic [6:0] f, logic [6:0] t, bit present, bit closing,
                           bit typed, vertex_result_t typed_res);
    int g;
    g = pick_gap();
    if (g > 0) begin
      s_axis_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {2'b00, t, f};
    s_axis_tuser <= present;
    s_axis_tlast <= closing;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (take_edge(f, t, present, closing)) begin
      if (typed) pending_vertices = {pending_vertices, typed_res};
      else foreach (run_out[k]) pending_vertices = {pending_vertices, run_out[k]};
    end
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 0;
    while (pending_vertices.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_vcount(logic [6:0] v);
    s_axis_tvalid <= 0;
    cfg_wr_en <= 1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 0;
    vcount_reg = v;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    vertex_result_t e;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_vertices.size() == 0) begin
          $error("unexpected vertex %0d", m_axis_tdata[6:0]);
          errors++;
        end else begin
          e = pending_vertices.pop_front();
          if (m_axis_tdata[6:0] !== e.vertex) begin
            $error("vertex exp %0d got %0d", e.vertex, m_axis_tdata[6:0]);
            errors++;
          end
          if (m_axis_tdata[12:7] !== e.comp) begin
            $error("component_number exp %0d got %0d", e.comp, m_axis_tdata[12:7]);
            errors++;
          end
          if (m_axis_tuser[0] !== e.comp_end) begin
            $error("component_end exp %0d got %0d", e.comp_end, m_axis_tuser[0]);
            errors++;
          end
          if (m_axis_tlast !== e.run_end) begin
            $error("last_result exp %0d got %0d", e.run_end, m_axis_tlast);
            errors++;
          end
          if (m_axis_tuser[1] !== e.dropped) begin
            $error("edges_dropped exp %0d got %0d", e.dropped, m_axis_tuser[1]);
            errors++;
          end
        end
      end
    end
    if (quiet) m_axis_tready <= 1;
    else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 0;
    end else if ($urandom_range(0, 99) < 80) m_axis_tready <= 1;
    else begin
      m_axis_tready <= 0;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 2);
    end
  end

  function automatic vertex_result_t res(int v, int c, bit ce, bit le, bit d);
    vertex_result_t r;
    r.vertex = 7'(v);
    r.comp = 6'(c);
    r.comp_end = ce;
    r.run_end = le;
    r.dropped = d;
    return r;
  endfunction

  function automatic edge_row_t row(bit ce, int cv, int f, int t, bit p, bit l,
                                    bit ty, vertex_result_t r);
    edge_row_t x;
    x.cfg_en = ce;
    x.cfg_val = 7'(cv);
    x.from_v = 7'(f);
    x.to_v = 7'(t);
    x.present = p;
    x.closing = l;
    x.typed = ty;
    x.typed_res = r;
    return x;
  endfunction

  initial begin
    edge_row_t      rows [$];
    vertex_result_t none;
    int             items, n, ecount;
    logic [6:0]     f, t;

    none = res(0, 0, 0, 0, 0);
    // single vertex, empty graph
    rows = {rows, row(1, 1, 0, 0, 0, 1, 1, res(1, 0, 1, 1, 0))};
    // zero count used as one, self loop
    rows = {rows, row(1, 0, 1, 1, 1, 1, 1, res(1, 0, 1, 1, 0))};
    // bad endpoint dropped
    rows = {rows, row(1, 1, 0, 1, 1, 1, 1, res(1, 0, 1, 1, 1))};
    // count above max clipped, extreme endpoints
    rows = {rows, row(1, 127, 64, 1, 1, 0, 0, none)};
    rows = {rows, row(0, 0, 1, 64, 1, 0, 0, none)};
    rows = {rows, row(0, 0, 65, 1, 1, 0, 0, none)};
    rows = {rows, row(0, 0, 127, 127, 1, 0, 0, none)};
    rows = {rows, row(0, 0, 2, 3, 1, 0, 0, none)};
    rows = {rows, row(0, 0, 127, 0, 0, 0, 0, none)};
    rows = {rows, row(0, 0, 3, 2, 1, 1, 0, none)};
    // count lowered after loading
    rows = {rows, row(1, 64, 5, 6, 1, 0, 0, none)};
    rows = {rows, row(0, 0, 6, 5, 1, 0, 0, none)};
    rows = {rows, row(1, 4, 1, 2, 1, 1, 0, none)};
    // directed ring 1->2->3->1
    rows = {rows, row(1, 3, 1, 2, 1, 0, 0, none)};
    rows = {rows, row(0, 0, 2, 3, 1, 0, 0, none)};
    rows = {rows, row(0, 0, 3, 1, 1, 1, 0, none)};
    // empty closing item with junk fields
    rows = {rows, row(1, 2, 85, 42, 0, 1, 0, none)};

    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].cfg_en) begin
        if (pending_vertices.size() > 0) wait_idle();
        write_vcount(rows[i].cfg_val);
      end
      send_edge(rows[i].from_v, rows[i].to_v, rows[i].present, rows[i].closing,
                rows[i].typed, rows[i].typed_res);
    end

    // edge store overflow
    wait_idle();
    write_vcount(7'd4);
    for (int k = 0; k < MAX_EDGES + 4; k++)
      send_edge(7'($urandom_range(1, 4)), 7'($urandom_range(1, 4)), 1,
                k == MAX_EDGES + 3, 0, none);

    items = 0;
    while (items < 75) begin
      quiet = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 9) < 7) begin
        wait_idle();
        case ($urandom_range(0, 19))
          0: write_vcount(7'd0);
          1: write_vcount(7'($urandom_range(65, 127)));
          2, 3, 4: write_vcount(7'($urandom_range(9, 64)));
          default: write_vcount(7'($urandom_range(1, 8)));
        endcase
      end
      n = live_count();
      ecount = $urandom_range(0, 12);
      for (int k = 0; k <= ecount; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          f = 7'($urandom_range(0, 127));
          t = 7'($urandom_range(0, 127));
        end else begin
          f = 7'($urandom_range(1, n));
          t = 7'($urandom_range(1, n));
        end
        if (k == ecount) send_edge(f, t, 1'($urandom_range(0, 1)), 1, 0, none);
        else if ($urandom_range(0, 9) == 0)
          send_edge(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)), 0, 0, 0, none);
        else send_edge(f, t, 1, 0, 0, none);
        items++;
      end
    end

    wait_idle();
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

[strongly_connected_components_top.f]
+incdir+hw/rtl
hw/rtl/scc_pkg.sv
hw/rtl/scc_ctrl.sv
hw/rtl/scc_datapath.sv
hw/rtl/strongly_connected_components_top.sv
hw/rtl/scc_checker.sv
verif/strongly_connected_components_top_tb.sv
